// ===== src/ssplit_pkg.sv =====
// Shared types and constants for the SQL statement splitter.
// No dependencies; used by every module under src.
`default_nettype none

package ssplit_pkg;

	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_OBRACE = 8'h7B;
	localparam logic [7:0] CH_CBRACE = 8'h7D;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// quote_mode codes
	localparam logic [1:0] QM_NONE   = 2'd0;
	localparam logic [1:0] QM_SINGLE = 2'd1;
	localparam logic [1:0] QM_DOUBLE = 2'd2;

	// skip_mode codes
	localparam logic [1:0] SK_NONE     = 2'd0;
	localparam logic [1:0] SK_VERBATIM = 2'd1;
	localparam logic [1:0] SK_COMMENT  = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       statement_end;
		logic       input_done;
		logic       quote_newline_warning;
	} out_item_t;

	typedef struct packed {
		logic [1:0] quote_mode;
		logic [1:0] skip_mode;
		logic       warned_this_statement;
		logic       statement_nonempty;
	} split_state_t;

endpackage

`default_nettype wire

// ===== src/sql_statement_splitter.sv =====
// Top level of the SQL statement splitter: input register, state, result register.
// Depends on ssplit_pkg, ssplit_step and ssplit_out_stage.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------------------
//  source  | src_valid | src_stall | src_item (data_byte, end_of_input)
//  result  | res_valid | res_stall | res_item (out_byte, statement_end,
//          |           |           |           input_done, quote_newline_warning)
//
// One item per cycle while the result side does not stall. An accepted item
// sits in the input register, is decoded against the splitter state, and its
// result (if any) is loaded into the result register as the item advances.
// Reset clears the input and result valid flags and all splitter state.
// A result stall holds the result register; the input register then stalls
// only if its item would produce a result, so dropped bytes keep flowing.
`default_nettype none

module sql_statement_splitter (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_stall,
	input  ssplit_pkg::in_item_t  src_item,
	output logic                  res_valid,
	input  logic                  res_stall,
	output ssplit_pkg::out_item_t res_item
);
	import ssplit_pkg::*;

	// input register
	logic         valid_s1;
	in_item_t     item_s1;

	// splitter state, updated as an item leaves the input register
	split_state_t state_q;
	split_state_t state_nxt;

	logic         step_vld;
	out_item_t    step_res;
	logic         slot_free;
	logic         advance;
	logic         accept;

	ssplit_step u_step (
		.item    (item_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.res_vld (step_vld),
		.res     (step_res)
	);

	// An item moves on when its result has room, or when it makes none.
	assign advance   = valid_s1 && (!step_vld || slot_free);
	assign src_stall = valid_s1 && !advance;
	assign accept    = src_valid && !src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= src_item;
		end
	end

	ssplit_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (advance && step_vld),
		.load_item  (step_res),
		.slot_free  (slot_free),
		.valid      (res_valid),
		.stall      (res_stall),
		.item       (res_item)
	);

	// A terminator or end of input leaves the splitter in its reset state.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_vld && (step_res.statement_end || step_res.input_done))
		|=> (state_q == '0))
		else $error("state not cleared after statement end or end of input");

	// Input side stalls only while an item is held in the input register.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> (valid_s1 && step_vld && !slot_free))
		else $error("input stalled without a blocked item");

	// The end-of-input marker carries nothing else.
	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_item.input_done) |->
		(res_item.out_byte == 8'h00 && !res_item.statement_end &&
		 !res_item.quote_newline_warning))
		else $error("end-of-input marker carries data");

	// A warning is given at most once per statement.
	a_warn_once: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_res.quote_newline_warning) |-> !state_q.warned_this_statement)
		else $error("second quote-newline warning in one statement");

endmodule

`default_nettype wire

// ===== src/ssplit_step.sv =====
// Next-state and result logic for one character of the splitter.
// Depends on ssplit_pkg.
`default_nettype none

module ssplit_step (
	input  ssplit_pkg::in_item_t     item,
	input  ssplit_pkg::split_state_t cur,
	output ssplit_pkg::split_state_t nxt,
	output logic                     res_vld,
	output ssplit_pkg::out_item_t    res
);
	import ssplit_pkg::*;

	logic [7:0] c;
	logic       is_term;

	assign c       = item.data_byte;
	assign is_term = (c == CH_SEMI) || (c == CH_OBRACE) || (c == CH_CBRACE);

	always_comb begin
		nxt     = cur;
		res_vld = 1'b0;
		res     = '0;
		if (item.end_of_input) begin
			nxt             = '0;
			res_vld         = 1'b1;
			res.input_done  = 1'b1;
		end else if (cur.skip_mode == SK_VERBATIM) begin
			// byte after a backslash goes out untouched
			nxt.skip_mode          = SK_NONE;
			nxt.statement_nonempty = 1'b1;
			res_vld                = 1'b1;
			res.out_byte           = c;
		end else if (cur.skip_mode != SK_NONE) begin
			if (c == CH_NL)
				nxt.skip_mode = SK_NONE;
		end else if (c == CH_NL) begin
			if (cur.quote_mode != QM_NONE && !cur.warned_this_statement) begin
				nxt.warned_this_statement = 1'b1;
				res.quote_newline_warning = 1'b1;
			end
			res_vld      = cur.statement_nonempty;
			res.out_byte = CH_SPACE;
		end else if (c == CH_BSLASH) begin
			nxt.skip_mode          = SK_VERBATIM;
			nxt.statement_nonempty = 1'b1;
			res_vld                = 1'b1;
			res.out_byte           = c;
		end else if (cur.quote_mode == QM_NONE && is_term) begin
			nxt               = '0;
			res_vld           = 1'b1;
			res.out_byte      = c;
			res.statement_end = 1'b1;
		end else if (cur.quote_mode == QM_NONE && c == CH_HASH) begin
			nxt.skip_mode = SK_COMMENT;
		end else begin
			if (cur.quote_mode == QM_NONE) begin
				if (c == CH_SQUOTE)
					nxt.quote_mode = QM_SINGLE;
				else if (c == CH_DQUOTE)
					nxt.quote_mode = QM_DOUBLE;
			end else if ((cur.quote_mode == QM_SINGLE && c == CH_SQUOTE) ||
			             (cur.quote_mode == QM_DOUBLE && c == CH_DQUOTE)) begin
				nxt.quote_mode = QM_NONE;
			end
			nxt.statement_nonempty = 1'b1;
			res_vld                = 1'b1;
			res.out_byte           = c;
		end
	end

endmodule

`default_nettype wire

// ===== src/ssplit_out_stage.sv =====
// Result register: holds an item while the sink stalls.
// Depends on ssplit_pkg.
`default_nettype none

module ssplit_out_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load_valid,
	input  ssplit_pkg::out_item_t load_item,
	output logic                  slot_free,
	output logic                  valid,
	input  logic                  stall,
	output ssplit_pkg::out_item_t item
);
	import ssplit_pkg::*;

	logic      valid_s2;
	out_item_t item_s2;

	assign slot_free = !valid_s2 || !stall;
	assign valid     = valid_s2;
	assign item      = item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (slot_free) begin
			valid_s2 <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && load_valid) begin
			item_s2 <= load_item;
		end
	end

endmodule

`default_nettype wire
